/* sv/scds_pkg.sv */
`timescale 1ns / 1ps
// Package for the SPI clock divider search block.
// Holds the command/status structs, codes and constants shared by all modules.
// No dependencies.
package scds_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned N_W = 6;
   localparam int unsigned PRE_W = 13;
   localparam int unsigned CAND_W = 2;
   localparam int unsigned PROD_W = 20;

   localparam logic [WORD_W-1:0] SRC_RESET = 32'd80000000;
   localparam logic [WORD_W-1:0] SLOWEST_WORD = 32'h7ffff000;
   localparam logic [WORD_W-1:0] BYPASS_WORD = 32'h80000000;
   localparam logic [N_W-1:0] N_FIRST = 6'd1;
   localparam logic [N_W-1:0] N_MAX = 6'h3f;
   localparam logic [PRE_W-1:0] PRE_MAX = 13'h1fff;
   localparam logic [CAND_W-1:0] CAND_LAST = 2'd3;
   localparam int unsigned SLOW_SHIFT = 19;

   typedef enum logic [1:0] {
      DIV_SRC_N,
      DIV_Q1_F,
      DIV_RATE
   } div_sel_type;

   typedef enum logic [1:0] {
      RES_BYPASS,
      RES_SLOWEST,
      RES_CAND,
      RES_BEST
   } res_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        init_search;
      logic        div_start;
      div_sel_type div_sel;
      logic        latch_q1;
      logic        latch_q2;
      logic        latch_pre;
      logic        latch_prod;
      logic        eval;
      logic        next_cand;
      logic        next_n;
      logic        load_result;
      res_sel_type res_sel;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic bypass;
      logic slow;
      logic div_done;
      logic rate_eq;
      logic cand_last;
      logic n_last;
      logic out_free;
   } status_type;

   function automatic logic [WORD_W-1:0] pack_word(input logic [N_W-1:0] n,
                                                   input logic [PRE_W-1:0] pre);
      logic [N_W:0] n_inc;
      n_inc = {1'b0, n} + {{N_W{1'b0}}, 1'b1};
      return {1'b0, pre, n, 6'd0, n_inc[N_W:1]};
   endfunction

endpackage

/* sv/scds_div.sv */
`timescale 1ns / 1ps
// Iterative unsigned 32-bit divider, two restoring steps per cycle.
// Depends on scds_pkg.
module scds_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [scds_pkg::WORD_W-1:0] dividend,
   input  logic [scds_pkg::WORD_W-1:0] divisor,
   output logic                        done,
   output logic [scds_pkg::WORD_W-1:0] quotient
);

   localparam int unsigned W = scds_pkg::WORD_W;
   localparam int unsigned ITER = W / 2;
   localparam int unsigned CNT_W = $clog2(ITER);

   logic [W-1:0]     rem_ff, rem_in, quo_ff, quo_in, dsr_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [W:0]       trial_a, trial_b;
   logic [W-1:0]     rem_a;
   logic             bit_a, bit_b;

   always_comb begin
      trial_a = {rem_ff, quo_ff[W-1]};
      bit_a = trial_a >= {1'b0, dsr_ff};
      rem_a = bit_a ? trial_a[W-1:0] - dsr_ff : trial_a[W-1:0];
      trial_b = {rem_a, quo_ff[W-2]};
      bit_b = trial_b >= {1'b0, dsr_ff};
   end

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = CNT_W'(ITER - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = bit_b ? trial_b[W-1:0] - dsr_ff : trial_b[W-1:0];
         quo_in = {quo_ff[W-3:0], bit_a, bit_b};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (start) begin
         dsr_ff <= divisor;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

/* sv/scds_dpath.sv */
`timescale 1ns / 1ps
// Datapath: source clock register, candidate registers, best tracking, output register.
// Depends on scds_pkg and scds_div.
module scds_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   input  logic [scds_pkg::WORD_W-1:0] csr_source_clock_hz,
   input  logic [scds_pkg::WORD_W-1:0] req_target_hz,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [scds_pkg::WORD_W-1:0] rsp_divider_word,
   input  scds_pkg::cmd_type           cmd,
   output scds_pkg::status_type        status
);

   localparam int unsigned W = scds_pkg::WORD_W;
   localparam int unsigned NW = scds_pkg::N_W;
   localparam int unsigned PW = scds_pkg::PRE_W;
   localparam int unsigned CW = scds_pkg::CAND_W;
   localparam int unsigned XW = scds_pkg::PROD_W;

   logic [W-1:0]  src_ff, target_ff, q1_ff, q2_ff;
   logic [PW-1:0] pre_ff, pre_in;
   logic [XW-1:0] prod_ff;
   logic [NW-1:0] n_ff;
   logic [CW-1:0] cand_ff;
   logic          have_best_ff;
   logic [W-1:0]  best_rate_ff, best_word_ff, result_ff, result_in;
   logic [W-1:0]  rsp_word_ff;
   logic          rsp_valid_ff;

   logic [W-1:0]  div_a, div_b, div_q;
   logic          div_done;
   logic [NW:0]   n_inc;
   logic [PW:0]   pre_inc;
   logic signed [W+1:0] p_s;
   logic          better;

   assign n_inc = {1'b0, n_ff} + {{NW{1'b0}}, 1'b1};
   assign pre_inc = {1'b0, pre_ff} + {{PW{1'b0}}, 1'b1};

   always_comb begin
      case (cmd.div_sel)
         scds_pkg::DIV_SRC_N: begin
            div_a = src_ff;
            div_b = {{(W-NW-1){1'b0}}, n_inc};
         end
         scds_pkg::DIV_Q1_F: begin
            div_a = q1_ff;
            div_b = target_ff;
         end
         scds_pkg::DIV_RATE: begin
            div_a = src_ff;
            div_b = {{(W-XW){1'b0}}, prod_ff};
         end
         default: begin
            div_a = src_ff;
            div_b = {{(W-XW){1'b0}}, prod_ff};
         end
      endcase
   end

   scds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      p_s = $signed({2'b00, q2_ff}) + $signed({{W{1'b0}}, cand_ff}) - $signed((W+2)'(2));
      if (p_s > $signed({{(W+2-PW){1'b0}}, scds_pkg::PRE_MAX})) begin
         pre_in = scds_pkg::PRE_MAX;
      end else if (p_s <= $signed((W+2)'(0))) begin
         pre_in = '0;
      end else begin
         pre_in = p_s[PW-1:0];
      end
   end

   assign better = (div_q < target_ff) && (!have_best_ff || div_q > best_rate_ff);

   always_comb begin
      case (cmd.res_sel)
         scds_pkg::RES_BYPASS:  result_in = scds_pkg::BYPASS_WORD;
         scds_pkg::RES_SLOWEST: result_in = scds_pkg::SLOWEST_WORD;
         scds_pkg::RES_CAND:    result_in = scds_pkg::pack_word(n_ff, pre_ff);
         scds_pkg::RES_BEST: begin
            if (cmd.eval && better) begin
               result_in = scds_pkg::pack_word(n_ff, pre_ff);
            end else begin
               result_in = have_best_ff ? best_word_ff : '0;
            end
         end
         default:               result_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         target_ff <= req_target_hz;
      end
      if (cmd.latch_q1) begin
         q1_ff <= div_q;
      end
      if (cmd.latch_q2) begin
         q2_ff <= div_q;
      end
      if (cmd.latch_pre) begin
         pre_ff <= pre_in;
      end
      if (cmd.latch_prod) begin
         prod_ff <= {{(XW-PW-1){1'b0}}, pre_inc} * {{(XW-NW-1){1'b0}}, n_inc};
      end
      if (cmd.init_search) begin
         n_ff <= scds_pkg::N_FIRST;
         cand_ff <= '0;
      end else if (cmd.next_n) begin
         n_ff <= n_ff + NW'(1);
         cand_ff <= '0;
      end else if (cmd.next_cand) begin
         cand_ff <= cand_ff + CW'(1);
      end
      if (cmd.eval && better) begin
         best_rate_ff <= div_q;
         best_word_ff <= scds_pkg::pack_word(n_ff, pre_ff);
      end
      if (cmd.load_result) begin
         result_ff <= result_in;
      end
      if (cmd.load_rsp) begin
         rsp_word_ff <= result_ff;
      end
      if (reset) begin
         src_ff <= scds_pkg::SRC_RESET;
         have_best_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            src_ff <= csr_source_clock_hz;
         end
         if (cmd.init_search) begin
            have_best_ff <= 1'b0;
         end else if (cmd.eval && better) begin
            have_best_ff <= 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.bypass = target_ff >= src_ff;
   assign status.slow = (target_ff == '0) || (target_ff < (src_ff >> scds_pkg::SLOW_SHIFT));
   assign status.div_done = div_done;
   assign status.rate_eq = div_q == target_ff;
   assign status.cand_last = cand_ff == scds_pkg::CAND_LAST;
   assign status.n_last = n_ff == scds_pkg::N_MAX;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_divider_word = rsp_word_ff;

endmodule

/* sv/scds_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences the special-case checks and the per-n candidate search.
// Depends on scds_pkg.
module scds_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  scds_pkg::status_type status,
   output scds_pkg::cmd_type    cmd
);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_CHECK = 11'b00000000010,
      ST_D1    = 11'b00000000100,
      ST_W1    = 11'b00000001000,
      ST_D2    = 11'b00000010000,
      ST_W2    = 11'b00000100000,
      ST_PRE   = 11'b00001000000,
      ST_MUL   = 11'b00010000000,
      ST_D3    = 11'b00100000000,
      ST_W3    = 11'b01000000000,
      ST_OUT   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.div_sel = scds_pkg::DIV_RATE;
      cmd.res_sel = scds_pkg::RES_BEST;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.bypass) begin
               cmd.load_result = 1'b1;
               cmd.res_sel = scds_pkg::RES_BYPASS;
               state_in = ST_OUT;
            end else if (status.slow) begin
               cmd.load_result = 1'b1;
               cmd.res_sel = scds_pkg::RES_SLOWEST;
               state_in = ST_OUT;
            end else begin
               cmd.init_search = 1'b1;
               state_in = ST_D1;
            end
         end
         ST_D1: begin
            cmd.div_start = 1'b1;
            cmd.div_sel = scds_pkg::DIV_SRC_N;
            state_in = ST_W1;
         end
         ST_W1: begin
            if (status.div_done) begin
               cmd.latch_q1 = 1'b1;
               state_in = ST_D2;
            end
         end
         ST_D2: begin
            cmd.div_start = 1'b1;
            cmd.div_sel = scds_pkg::DIV_Q1_F;
            state_in = ST_W2;
         end
         ST_W2: begin
            if (status.div_done) begin
               cmd.latch_q2 = 1'b1;
               state_in = ST_PRE;
            end
         end
         ST_PRE: begin
            cmd.latch_pre = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.latch_prod = 1'b1;
            state_in = ST_D3;
         end
         ST_D3: begin
            cmd.div_start = 1'b1;
            cmd.div_sel = scds_pkg::DIV_RATE;
            state_in = ST_W3;
         end
         ST_W3: begin
            if (status.div_done) begin
               if (status.rate_eq) begin
                  cmd.load_result = 1'b1;
                  cmd.res_sel = scds_pkg::RES_CAND;
                  state_in = ST_OUT;
               end else begin
                  cmd.eval = 1'b1;
                  if (!status.cand_last) begin
                     cmd.next_cand = 1'b1;
                     state_in = ST_PRE;
                  end else if (!status.n_last) begin
                     cmd.next_n = 1'b1;
                     state_in = ST_D1;
                  end else begin
                     cmd.load_result = 1'b1;
                     cmd.res_sel = scds_pkg::RES_BEST;
                     state_in = ST_OUT;
                  end
               end
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/spi_clock_divider_search_top.sv */
`timescale 1ns / 1ps
// Top level of the SPI clock divider search: controller plus datapath.
// Depends on scds_pkg, scds_ctrl, scds_dpath, scds_div.
//
//   channel  ports                              direction  moves
//   req      req_valid/ready, req_target_hz     in         one request per search
//   rsp      rsp_valid/ready, rsp_divider_word  out        one divider word per request
//   csr      csr_valid/ready, csr_source_clock_hz in       source clock register write
//
// Bypass and slowest cases skip the search: the check state loads the result
// register, then the output state loads the response register once it is free.
// A full search runs two divider passes per n for the base prescaler, then four
// candidates, each with its own pass, over n = 1..63 on the shared divider.
// Synchronous active-high reset; no clearing pass. csr_ready is always high.
// A new request is taken once the previous one sits in the output register.
module spi_clock_divider_search_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [scds_pkg::WORD_W-1:0] req_target_hz,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [scds_pkg::WORD_W-1:0] rsp_divider_word,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [scds_pkg::WORD_W-1:0] csr_source_clock_hz
);

   scds_pkg::cmd_type    cmd;
   scds_pkg::status_type status;

   assign csr_ready = 1'b1;

   scds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   scds_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_source_clock_hz (csr_source_clock_hz),
      .req_target_hz       (req_target_hz),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_divider_word    (rsp_divider_word),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

/* sv/scds_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the SPI clock divider search top level.
// Depends on scds_pkg; bound to spi_clock_divider_search_top.
module scds_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [scds_pkg::WORD_W-1:0] rsp_divider_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_divider_word))
      else $error("rsp changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while search pending");

   a_rsp_from_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a pending request");

endmodule

bind spi_clock_divider_search_top scds_checker u_scds_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_divider_word (rsp_divider_word)
);

/* test/tb_spi_clock_divider_search_top.sv */
`timescale 1ns / 1ps
// Testbench for spi_clock_divider_search_top: directed, back-pressure and random
// requests checked against a divider search predictor inside this file.
// Depends on scds_pkg and spi_clock_divider_search_top.
module tb_spi_clock_divider_search_top;

   localparam int unsigned CYCLE_LIMIT = 4000000;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [scds_pkg::WORD_W-1:0] req_target_hz;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [scds_pkg::WORD_W-1:0] rsp_divider_word;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [scds_pkg::WORD_W-1:0] csr_source_clock_hz;

   logic [scds_pkg::WORD_W-1:0] source_clock_shadow = scds_pkg::SRC_RESET;
   logic [scds_pkg::WORD_W-1:0] divider_expect_q[$];
   int unsigned                 words_sent = 0;
   int unsigned                 words_seen = 0;
   int unsigned                 mismatches = 0;
   int unsigned                 cycle_count = 0;
   bit                          idling_on = 1'b1;
   int unsigned                 long_hold_cycles = 0;

   spi_clock_divider_search_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_target_hz       (req_target_hz),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_divider_word    (rsp_divider_word),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_source_clock_hz (csr_source_clock_hz)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [scds_pkg::WORD_W-1:0] predict_divider_word(
      input logic [scds_pkg::WORD_W-1:0] src, input logic [scds_pkg::WORD_W-1:0] f);
      logic [scds_pkg::WORD_W-1:0] best_word;
      logic [scds_pkg::WORD_W-1:0] best_rate;
      logic [scds_pkg::WORD_W-1:0] rate;
      logic [scds_pkg::WORD_W-1:0] divisor;
      logic [63:0]                 quot;
      logic [scds_pkg::PRE_W-1:0]  pre;
      bit                          have_best;
      longint                      base;
      longint                      p;
      best_word = '0;
      best_rate = '0;
      have_best = 1'b0;
      if (f >= src) return scds_pkg::BYPASS_WORD;
      if (f == '0) return scds_pkg::SLOWEST_WORD;
      if (f < (src >> scds_pkg::SLOW_SHIFT)) return scds_pkg::SLOWEST_WORD;
      for (int n = 1; n <= int'(scds_pkg::N_MAX); n++) begin
         quot = ({32'd0, src} / 64'(n + 1)) / {32'd0, f};
         base = longint'(quot) - 1;
         for (int v = -1; v <= 2; v++) begin
            p = base + v;
            if (p > longint'(scds_pkg::PRE_MAX))
               pre = scds_pkg::PRE_MAX;
            else if (p <= 0)
               pre = '0;
            else
               pre = p[scds_pkg::PRE_W-1:0];
            divisor = (32'(pre) + 32'd1) * 32'(n + 1);
            rate = src / divisor;
            if (rate == f)
               return {1'b0, pre, 6'(n), 6'd0, 6'((n + 1) / 2)};
            if (rate < f && (!have_best || (f - rate) < (f - best_rate))) begin
               have_best = 1'b1;
               best_rate = rate;
               best_word = {1'b0, pre, 6'(n), 6'd0, 6'((n + 1) / 2)};
            end
         end
      end
      return have_best ? best_word : '0;
   endfunction

   task automatic note_mismatch(input string what,
                                input logic [scds_pkg::WORD_W-1:0] exp_word,
                                input logic [scds_pkg::WORD_W-1:0] got_word);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch (%s) at %0t: expected %h, got %h", what, $realtime, exp_word,
                  got_word);
   endtask

   // request/config monitor and response checker
   always @(posedge clock) begin
      logic [scds_pkg::WORD_W-1:0] exp_word;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else if (!reset) begin
         if (csr_valid && csr_ready)
            source_clock_shadow = csr_source_clock_hz;
         if (req_valid && req_ready)
            divider_expect_q.push_back(predict_divider_word(source_clock_shadow,
                                                            req_target_hz));
         if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (divider_expect_q.size() == 0) begin
               note_mismatch("unexpected", 'x, rsp_divider_word);
            end else begin
               exp_word = divider_expect_q.pop_front();
               if (exp_word !== rsp_divider_word)
                  note_mismatch("divider_word", exp_word, rsp_divider_word);
            end
         end
      end
   end

   // response side: random stalls plus a long hold on request
   initial begin : rsp_side
      int unsigned stall;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_cycles != 0) begin
            stall = long_hold_cycles;
            long_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_target(input logic [scds_pkg::WORD_W-1:0] f);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_target_hz <= f;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic drain_requests();
      req_valid <= 1'b0;
      while (words_seen != words_sent) @(posedge clock);
   endtask

   task automatic write_source_clock(input logic [scds_pkg::WORD_W-1:0] src);
      drain_requests();
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_source_clock_hz <= src;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [scds_pkg::WORD_W-1:0] pick_source();
      logic [scds_pkg::WORD_W-1:0] src;
      case ($urandom_range(0, 3))
         0: src = $urandom;
         1: src = $urandom >> $urandom_range(0, 31);
         2: src = $urandom_range(1, 1000);
         default: src = 32'd160000000;
      endcase
      return (src == '0) ? 32'd1 : src;
   endfunction

   function automatic logic [scds_pkg::WORD_W-1:0] pick_target(
      input logic [scds_pkg::WORD_W-1:0] src);
      logic [32:0]                 span;
      logic [scds_pkg::WORD_W-1:0] lo;
      logic [scds_pkg::WORD_W-1:0] f;
      int unsigned                 n;
      int unsigned                 pre;
      lo = src >> scds_pkg::SLOW_SHIFT;
      case ($urandom_range(0, 9))
         0: begin
            span = 33'h1_0000_0000 - {1'b0, src};
            f = 32'({1'b0, src} + ({1'b0, $urandom} % span));
         end
         1: f = (lo == '0) ? '0 : ($urandom % lo);
         2, 3, 4, 5: begin
            // exact hit at a small n
            n = $urandom_range(1, 12);
            pre = $urandom_range(0, 8191) >> $urandom_range(0, 13);
            f = src / ((pre + 1) * (n + 1));
            if (f == '0) f = 32'd1;
         end
         default: f = lo + (($urandom >> $urandom_range(0, 31)) % (src - lo));
      endcase
      return f;
   endfunction

   task automatic test_default_clock();
      logic [scds_pkg::WORD_W-1:0] targets[] = '{32'd0, 32'd1, 32'd151, 32'd152,
                                                 32'd115200, 32'd1000000, 32'd40000000,
                                                 32'd79999999, 32'd80000000,
                                                 32'hffffffff, 32'd26666666};
      foreach (targets[i]) send_target(targets[i]);
   endtask

   task automatic test_clock_extremes();
      logic [scds_pkg::WORD_W-1:0] low_targets[] = '{32'd0, 32'd1, 32'hffffffff};
      logic [scds_pkg::WORD_W-1:0] high_targets[] = '{32'd0, 32'd8190, 32'd8191,
                                                      32'h80000000, 32'h55555555,
                                                      32'hfffffffe, 32'hffffffff};
      write_source_clock(32'd1);
      foreach (low_targets[i]) send_target(low_targets[i]);
      write_source_clock(32'hffffffff);
      foreach (high_targets[i]) send_target(high_targets[i]);
      write_source_clock(32'd2);
      send_target(32'd1);
      send_target(32'd2);
   endtask

   task automatic test_back_pressure();
      logic [scds_pkg::WORD_W-1:0] targets[] = '{32'hffffffff, 32'd0, 32'd40000000,
                                                 32'd80000000, 32'd100, 32'd20000000,
                                                 32'd90000000, 32'd1};
      write_source_clock(scds_pkg::SRC_RESET);
      long_hold_cycles = 600;
      while (rsp_ready) @(posedge clock);
      foreach (targets[i]) send_target(targets[i]);
   endtask

   task automatic test_random_requests();
      logic [scds_pkg::WORD_W-1:0] src;
      for (int phase = 0; phase < 4; phase++) begin
         src = (phase == 0) ? scds_pkg::SRC_RESET : pick_source();
         write_source_clock(src);
         repeat (12) send_target(pick_target(src));
      end
   endtask

   task automatic test_steady_stream();
      logic [scds_pkg::WORD_W-1:0] src;
      src = pick_source();
      write_source_clock(src);
      idling_on = 1'b0;
      repeat (28) send_target(pick_target(src));
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_target_hz <= '0;
      csr_valid <= 1'b0;
      csr_source_clock_hz <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_clock();
      test_clock_extremes();
      test_back_pressure();
      test_random_requests();
      test_steady_stream();
      drain_requests();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && divider_expect_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* filelist.f */
sv/scds_pkg.sv
sv/scds_div.sv
sv/scds_dpath.sv
sv/scds_ctrl.sv
sv/spi_clock_divider_search_top.sv
sv/scds_checker.sv
test/tb_spi_clock_divider_search_top.sv
